// ===== design/ifx_pkg.sv =====
// ----------------------------------------------------------------------------
// ifx_pkg: shared types and constants for the infix expression evaluator
// Character codes, request structs, sequencer states and the control and
// status structs of the shared multiply/divide unit.
// ----------------------------------------------------------------------------
package ifx_pkg;

    // Default datapath width for term and sum arithmetic
    localparam int VALUE_WIDTH_DEF = 32;
    // Width of the result value field
    localparam int OUT_WIDTH = 32;

    // Character codes
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Input request: one character of the expression
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_req_t;

    // Output request: value and status of one expression
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] value;
        logic                        status;
    } out_req_t;

    // Top-level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_BUSY,
        ST_EMIT
    } ifx_state_t;

    // Shared unit operations
    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } mdu_op_t;

    // Shared unit phases
    typedef enum logic [1:0] {
        MDU_IDLE,
        MDU_PREP,
        MDU_STEP,
        MDU_FIX
    } mdu_phase_t;

    // Control from the sequencer to the shared unit
    typedef struct packed {
        logic    start;
        mdu_op_t op;
    } mdu_ctrl_t;

    // Status from the shared unit to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mdu_stat_t;

endpackage

// ===== design/ifx_muldiv.sv =====
// ----------------------------------------------------------------------------
// ifx_muldiv: iterative multiply/divide unit around one shared adder
// Multiply keeps the low VALUE_WIDTH bits by shift-and-add; divide is a
// restoring divider on magnitudes with a sign fix-up, truncating toward zero.
// ----------------------------------------------------------------------------
module ifx_muldiv
    import ifx_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mdu_ctrl_t              ctrl,
    input  logic [VALUE_WIDTH-1:0] opa,
    input  logic [VALUE_WIDTH-2:0] opb,
    output logic [VALUE_WIDTH-1:0] result,
    output mdu_stat_t              stat
);

    localparam int VW    = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VW);

    mdu_phase_t          phase_reg, phase_next;
    mdu_op_t             op_reg, op_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [VW:0]         acc_reg, acc_next;
    logic [VW-1:0]       x_reg, x_next;
    logic [VW-1:0]       y_reg, y_next;
    logic                neg_reg, neg_next;
    logic [VW-1:0]       res_reg, res_next;
    logic                done_reg, done_next;

    logic [VW:0]         add_a, add_b, sum, rem_sh;
    logic                sub;

    assign rem_sh = {acc_reg[VW-1:0], x_reg[VW-1]};

    // Select the shared adder operands for the current phase
    always_comb begin
        add_a = '0;
        add_b = {1'b0, x_reg};
        sub   = 1'b0;
        unique case (phase_reg)
            MDU_PREP, MDU_FIX: begin
                sub = neg_reg;
            end
            MDU_STEP: begin
                if (op_reg == MDU_MUL) begin
                    add_a = acc_reg;
                end else begin
                    add_a = rem_sh;
                    add_b = {1'b0, y_reg};
                    sub   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign sum = add_a + (sub ? ~add_b : add_b) + {{VW{1'b0}}, sub};

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MDU_IDLE: if (ctrl.start) phase_next = MDU_PREP;
            MDU_PREP: phase_next = MDU_STEP;
            MDU_STEP: if (cnt_reg == '0) phase_next = MDU_FIX;
            MDU_FIX:  phase_next = MDU_IDLE;
            default:  phase_next = MDU_IDLE;
        endcase
    end

    // Datapath updates per phase
    always_comb begin
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        unique case (phase_reg)
            MDU_IDLE: begin
                if (ctrl.start) begin
                    op_next  = ctrl.op;
                    cnt_next = CNT_W'(VW - 1);
                    acc_next = '0;
                    x_next   = opa;
                    y_next   = {1'b0, opb};
                    neg_next = (ctrl.op == MDU_DIV) && opa[VW-1];
                end
            end
            MDU_PREP: begin
                // take the dividend magnitude
                x_next = sum[VW-1:0];
            end
            MDU_STEP: begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (op_reg == MDU_MUL) begin
                    if (y_reg[0]) acc_next = {1'b0, sum[VW-1:0]};
                    x_next = {x_reg[VW-2:0], 1'b0};
                    y_next = {1'b0, y_reg[VW-1:1]};
                end else begin
                    acc_next = sum[VW] ? rem_sh : sum;
                    x_next   = {x_reg[VW-2:0], ~sum[VW]};
                end
            end
            MDU_FIX: begin
                res_next  = (op_reg == MDU_MUL) ? acc_reg[VW-1:0] : sum[VW-1:0];
                done_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MDU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign result    = res_reg;
    assign stat.busy = (phase_reg != MDU_IDLE);
    assign stat.done = done_reg;

endmodule

// ===== design/infix_four_op_evaluator.sv =====
// ----------------------------------------------------------------------------
// infix_four_op_evaluator: streaming evaluator for + - * / expressions
// Takes one ASCII character per request and returns one result request
// for each expression, at the character flagged last.
// ----------------------------------------------------------------------------
// Usage:
//   s_req carries char_code and last_char under s_valid/s_ready. Digits build
//   a saturating decimal number, spaces are skipped, any other character
//   closes the number under the pending operator. m_req carries the value
//   (sum plus last term, two's complement) and a division-by-zero status
//   under m_valid/m_ready.
//   Sequence: a digit or space is taken in the idle state alone. A closing
//   character moves to the close state, which settles + or -, an unknown
//   operator or a divide by zero; for * or / the shared multiply/divide unit
//   then loads, takes the magnitude, runs one bit a cycle, does the sign
//   fix-up and raises done. The last character adds the emit state to load
//   the output register. s_ready is high only while the sequencer is idle.
//   Stall: the result waits in the output register; the next expression is
//   accepted meanwhile and only its own last character waits for the slot.
//   Reset (aresetn low, synchronous) clears the expression state to an
//   empty sum with a pending '+', and drops any undelivered result.
// ----------------------------------------------------------------------------
module infix_four_op_evaluator
    import ifx_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output out_req_t m_req
);

    localparam int VW = VALUE_WIDTH;

    ifx_state_t        state_reg, state_next;
    logic [VW-2:0]     number_reg, number_next;
    logic [7:0]        pending_reg, pending_next;
    logic [VW-1:0]     sum_reg, sum_next;
    logic [VW-1:0]     term_reg, term_next;
    logic              divz_reg, divz_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;
    out_req_t          out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    mdu_ctrl_t         mdu_ctrl;
    mdu_stat_t         mdu_stat;
    logic [VW-1:0]     mdu_result;

    logic              s_fire, is_digit, closes, slot_free;
    logic [VW+2:0]     times10;
    logic [VW-2:0]     number_sat;
    logic [VW-1:0]     number_ext, total;
    logic [VW+OUT_WIDTH-1:0] total_ext;

    assign s_fire    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign is_digit  = (s_req.char_code >= CHAR_ZERO) && (s_req.char_code <= CHAR_NINE);
    assign closes    = s_req.last_char || (!is_digit && (s_req.char_code != CHAR_SPACE));

    // Append a digit, saturate at the largest positive value
    assign times10 = {1'b0, number_reg, 3'b000} + {2'b00, number_reg, 1'b0}
                     + (VW+3)'(s_req.char_code[3:0]);
    assign number_sat = (times10 > (VW+3)'({(VW-1){1'b1}})) ? {(VW-1){1'b1}}
                                                           : times10[VW-2:0];

    assign number_ext = {1'b0, number_reg};
    assign total      = sum_reg + term_reg;
    assign total_ext  = {{OUT_WIDTH{total[VW-1]}}, total};

    ifx_muldiv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mdu_ctrl),
        .opa     (term_reg),
        .opb     (number_reg),
        .result  (mdu_result),
        .stat    (mdu_stat)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && closes) state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                if (pending_reg == CHAR_STAR
                    || (pending_reg == CHAR_SLASH && number_reg != '0)) begin
                    state_next = ST_BUSY;
                end else if (last_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_BUSY: begin
                if (mdu_stat.done) state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (slot_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and handshake outputs
    always_comb begin
        number_next  = number_reg;
        pending_next = pending_reg;
        sum_next     = sum_reg;
        term_next    = term_reg;
        divz_next    = divz_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mdu_ctrl     = '{start: 1'b0, op: MDU_MUL};
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_fire) begin
                    if (is_digit) number_next = number_sat;
                    char_next = s_req.char_code;
                    last_next = s_req.last_char;
                end
            end
            ST_CLOSE: begin
                // close the number under the pending operator
                number_next  = '0;
                pending_next = char_reg;
                case (pending_reg)
                    CHAR_PLUS: begin
                        sum_next  = total;
                        term_next = number_ext;
                    end
                    CHAR_MINUS: begin
                        sum_next  = total;
                        term_next = '0 - number_ext;
                    end
                    CHAR_STAR: begin
                        mdu_ctrl = '{start: 1'b1, op: MDU_MUL};
                    end
                    CHAR_SLASH: begin
                        if (number_reg == '0) begin
                            divz_next = 1'b1;
                        end else begin
                            mdu_ctrl = '{start: 1'b1, op: MDU_DIV};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_BUSY: begin
                if (mdu_stat.done) term_next = mdu_result;
            end
            ST_EMIT: begin
                // hand over the result, then start a fresh expression
                if (slot_free) begin
                    out_next.value  = total_ext[OUT_WIDTH-1:0];
                    out_next.status = divz_reg;
                    m_valid_next    = 1'b1;
                    number_next     = '0;
                    pending_next    = CHAR_PLUS;
                    sum_next        = '0;
                    term_next       = '0;
                    divz_next       = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            number_reg  <= '0;
            pending_reg <= CHAR_PLUS;
            sum_reg     <= '0;
            term_reg    <= '0;
            divz_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            number_reg  <= number_next;
            pending_reg <= pending_next;
            sum_reg     <= sum_next;
            term_reg    <= term_next;
            divz_reg    <= divz_next;
        end
        char_reg <= char_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_req   = out_reg;

endmodule
